// ===== hw/rtl/vapa_pkg.sv =====
package vapa_pkg;

    localparam int IDX_BITS      = 30;
    localparam int SIZE_BITS     = 11;
    localparam int CODE_BITS     = 3;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 11;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = 2;

    // Cycles of input hold-off while the derived strides settle.
    localparam logic [1:0] SETUP_CYCLES = 2'd2;

    localparam logic [1:0] AXIS_NONE = 2'd3;

    // Signed axis codes: source axis 1=x 2=y 3=z, negated to reverse it.
    localparam logic [CODE_BITS-1:0] CODE_X     = 3'b001;
    localparam logic [CODE_BITS-1:0] CODE_Y     = 3'b010;
    localparam logic [CODE_BITS-1:0] CODE_Z     = 3'b011;
    localparam logic [CODE_BITS-1:0] CODE_NEG_X = 3'b111;
    localparam logic [CODE_BITS-1:0] CODE_NEG_Y = 3'b110;
    localparam logic [CODE_BITS-1:0] CODE_NEG_Z = 3'b101;

    typedef logic [IDX_BITS-1:0] idx_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_SIZE_X = 3'd0,
        CFG_SIZE_Y = 3'd1,
        CFG_SIZE_Z = 3'd2,
        CFG_AXIS0  = 3'd3,
        CFG_AXIS1  = 3'd4,
        CFG_AXIS2  = 3'd5
    } cfg_idx_t;

    // Derived per-source-axis mapping, handed from setup to the back end.
    typedef struct packed {
        logic             ok;
        logic [2:0]       rev;
        logic [2:0][IDX_BITS-1:0] stride;
    } setup_t;

    // Source axis selected by a signed axis code, AXIS_NONE when the code is bad.
    function automatic logic [1:0] code_axis(input logic [CODE_BITS-1:0] code);
        logic [1:0] axis;
        case (code) inside
            CODE_X, CODE_NEG_X: axis = 2'd0;
            CODE_Y, CODE_NEG_Y: axis = 2'd1;
            CODE_Z, CODE_NEG_Z: axis = 2'd2;
            default:            axis = AXIS_NONE;
        endcase
        return axis;
    endfunction

endpackage

// ===== hw/rtl/vapa_if.sv =====
interface vapa_in_if #(parameter int DATA_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [DATA_BITS-1:0] voxel_in;

    modport source (output valid, output voxel_in, input ready);
    modport sink   (input valid, input voxel_in, output ready);
endinterface

interface vapa_out_if #(parameter int DATA_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic [29:0]          dest_index;
    logic [DATA_BITS-1:0] voxel_out;
    logic                 last_voxel;
    logic                 config_error;

    modport source (output valid, output dest_index, output voxel_out,
                    output last_voxel, output config_error, input ready);
    modport sink   (input valid, input dest_index, input voxel_out,
                    input last_voxel, input config_error, output ready);
endinterface

interface vapa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/vapa_setup.sv =====
module vapa_setup #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    vapa_cfg_if.sink                             cfg,
    output vapa_pkg::setup_t                     setup,
    output logic [2:0][$clog2(MAX_DIM)-1:0]      ext_m1,
    output logic                                 busy,
    output logic                                 clear
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int EW = $clog2(MAX_DIM + 1);
    localparam int SW = vapa_pkg::SIZE_BITS;
    localparam int XW = vapa_pkg::IDX_BITS;

    logic [2:0][SW-1:0]                   size_reg, size_next;
    logic [2:0][vapa_pkg::CODE_BITS-1:0]  code_reg, code_next;
    logic [1:0]                           busy_reg, busy_next;
    logic                                 hit;

    logic [2:0][CW-1:0] ext_m1_next;
    logic [2:0][1:0]    axis;
    logic [2:0][1:0]    dst_next;
    logic [2:0]         rev_next;
    logic               ok_next;

    logic [2:0][CW-1:0] a_ext_m1_reg;
    logic [2:0][1:0]    a_dst_reg;
    logic [2:0]         a_rev_reg;
    logic               a_ok_reg;
    logic [EW-1:0]      a_dn0_reg, a_dn1_reg;
    logic [XW-1:0]      b_dn01_reg;
    logic [2:0][XW-1:0] c_stride_reg;

    function automatic logic [EW-1:0] extent_of(input logic [1:0] sel,
                                                 input logic [2:0][CW-1:0] e_m1);
        logic [EW-1:0] e;
        case (sel)
            2'd0:    e = EW'(e_m1[0]) + 1'b1;
            2'd1:    e = EW'(e_m1[1]) + 1'b1;
            2'd2:    e = EW'(e_m1[2]) + 1'b1;
            default: e = '0;
        endcase
        return e;
    endfunction

    assign cfg.ready = 1'b1;

    always_comb
    begin
        size_next = size_reg;
        code_next = code_reg;
        hit       = 1'b1;
        case (cfg.index)
            vapa_pkg::CFG_SIZE_X: size_next[0] = cfg.data;
            vapa_pkg::CFG_SIZE_Y: size_next[1] = cfg.data;
            vapa_pkg::CFG_SIZE_Z: size_next[2] = cfg.data;
            vapa_pkg::CFG_AXIS0:  code_next[0] = cfg.data[vapa_pkg::CODE_BITS-1:0];
            vapa_pkg::CFG_AXIS1:  code_next[1] = cfg.data[vapa_pkg::CODE_BITS-1:0];
            vapa_pkg::CFG_AXIS2:  code_next[2] = cfg.data[vapa_pkg::CODE_BITS-1:0];
            default:              hit = 1'b0;
        endcase
        clear = cfg.valid && cfg.ready && hit;
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (clear)
            busy_next = vapa_pkg::SETUP_CYCLES;
        else if (busy_reg != 2'd0)
            busy_next = busy_reg - 2'd1;
    end

    assign busy = (busy_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= {SW'(1), SW'(1), SW'(1)};
            code_reg <= {vapa_pkg::CODE_Z, vapa_pkg::CODE_Y, vapa_pkg::CODE_X};
            busy_reg <= vapa_pkg::SETUP_CYCLES;
        end
        else
        begin
            if (clear)
            begin
                size_reg <= size_next;
                code_reg <= code_next;
            end
            busy_reg <= busy_next;
        end
    end

    // Clamp extents and invert the code map to a per-source-axis view.
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            if (size_reg[a] == '0)
                ext_m1_next[a] = '0;
            else if (32'(size_reg[a]) > 32'(MAX_DIM))
                ext_m1_next[a] = CW'(MAX_DIM - 1);
            else
                ext_m1_next[a] = CW'(size_reg[a] - 1'b1);
        end
        for (int j = 0; j < 3; j++)
            axis[j] = vapa_pkg::code_axis(code_reg[j]);
        ok_next = (axis[0] != vapa_pkg::AXIS_NONE) && (axis[1] != vapa_pkg::AXIS_NONE) &&
                  (axis[2] != vapa_pkg::AXIS_NONE) && (axis[0] != axis[1]) &&
                  (axis[0] != axis[2]) && (axis[1] != axis[2]);
        for (int a = 0; a < 3; a++)
        begin
            dst_next[a] = 2'd0;
            rev_next[a] = 1'b0;
            for (int j = 0; j < 3; j++)
            begin
                if (axis[j] == 2'(a))
                begin
                    dst_next[a] = 2'(j);
                    rev_next[a] = code_reg[j][vapa_pkg::CODE_BITS-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_ext_m1_reg <= ext_m1_next;
        a_dst_reg    <= dst_next;
        a_rev_reg    <= rev_next;
        a_ok_reg     <= ok_next;
        a_dn0_reg    <= extent_of(axis[0], ext_m1_next);
        a_dn1_reg    <= extent_of(axis[1], ext_m1_next);
        b_dn01_reg   <= XW'(a_dn0_reg * a_dn1_reg);
        for (int a = 0; a < 3; a++)
        begin
            case (a_dst_reg[a])
                2'd0:    c_stride_reg[a] <= XW'(1);
                2'd1:    c_stride_reg[a] <= XW'(a_dn0_reg);
                default: c_stride_reg[a] <= b_dn01_reg;
            endcase
        end
    end

    assign setup.ok     = a_ok_reg;
    assign setup.rev    = a_rev_reg;
    assign setup.stride = c_stride_reg;
    assign ext_m1       = a_ext_m1_reg;

endmodule

// ===== hw/rtl/vapa_front.sv =====
module vapa_front #(
    parameter int MAX_DIM   = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    vapa_in_if.sink                                     voxel,
    input  logic [2:0][$clog2(MAX_DIM)-1:0]             ext_m1,
    input  logic                                        busy,
    input  logic                                        clear,
    input  logic                                        full,
    output logic                                        push,
    output logic [3*$clog2(MAX_DIM)+DATA_BITS:0]        entry
);

    localparam int CW = $clog2(MAX_DIM);

    logic [2:0][CW-1:0] cnt_reg, cnt_next;
    logic [2:0]         at_end;
    logic               last;

    assign voxel.ready = !busy && !full;
    assign push        = voxel.valid && voxel.ready;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
            at_end[a] = (cnt_reg[a] == ext_m1[a]);
        last     = &at_end;
        cnt_next = cnt_reg;
        if (clear)
            cnt_next = '0;
        else if (push)
        begin
            // Raster walk: x fastest, carry into y, then z.
            cnt_next[0] = at_end[0] ? '0 : cnt_reg[0] + 1'b1;
            if (at_end[0])
            begin
                cnt_next[1] = at_end[1] ? '0 : cnt_reg[1] + 1'b1;
                if (at_end[1])
                    cnt_next[2] = at_end[2] ? '0 : cnt_reg[2] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    assign entry = {cnt_reg, last, voxel.voxel_in};

endmodule

// ===== hw/rtl/vapa_fifo.sv =====
module vapa_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             not_empty
);

    localparam int PW = vapa_pkg::QPTR_BITS;

    logic [WIDTH-1:0] slot_reg [vapa_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full      = (count_reg == (PW+1)'(vapa_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// ===== hw/rtl/vapa_back.sv =====
module vapa_back #(
    parameter int MAX_DIM   = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_valid,
    input  logic [3*$clog2(MAX_DIM)+DATA_BITS:0]        q_data,
    output logic                                        pop,
    input  vapa_pkg::setup_t                            setup,
    input  logic [2:0][$clog2(MAX_DIM)-1:0]             ext_m1,
    vapa_out_if.source                                  result
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int XW = vapa_pkg::IDX_BITS;

    logic [2:0][CW-1:0]   cnt;
    logic [2:0][CW-1:0]   coord;
    logic [2:0][XW-1:0]   prod;
    logic                 s1_en, s2_en;

    logic                 s1_valid_reg, s2_valid_reg;
    logic [2:0][XW-1:0]   s1_prod_reg;
    logic [DATA_BITS-1:0] s1_voxel_reg, s2_voxel_reg;
    logic                 s1_last_reg, s2_last_reg;
    logic [XW-1:0]        s2_index_reg;
    logic                 s2_err_reg;

    assign cnt = q_data[3*CW+DATA_BITS:DATA_BITS+1];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            coord[a] = setup.rev[a] ? (ext_m1[a] - cnt[a]) : cnt[a];
            prod[a]  = XW'(coord[a]) * setup.stride[a];
        end
    end

    assign s2_en = !s2_valid_reg || result.ready;
    assign s1_en = !s1_valid_reg || s2_en;
    assign pop   = q_valid && s1_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= q_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_prod_reg  <= prod;
            s1_voxel_reg <= q_data[DATA_BITS-1:0];
            s1_last_reg  <= q_data[DATA_BITS];
        end
        if (s2_en && s1_valid_reg)
        begin
            s2_index_reg <= setup.ok ? (s1_prod_reg[0] + s1_prod_reg[1] + s1_prod_reg[2])
                                     : '0;
            s2_err_reg   <= !setup.ok;
            s2_voxel_reg <= s1_voxel_reg;
            s2_last_reg  <= s1_last_reg;
        end
    end

    assign result.valid        = s2_valid_reg;
    assign result.dest_index   = s2_index_reg;
    assign result.voxel_out    = s2_voxel_reg;
    assign result.last_voxel   = s2_last_reg;
    assign result.config_error = s2_err_reg;

endmodule

// ===== hw/rtl/volume_axis_permute_address.sv =====
// Streams a 3D volume in source raster order (x fastest) and tags each voxel with its
// linear index in an axis-permuted, optionally flipped destination volume. Registers
// 0..2 set the source extents (0 reads as 1, anything above MAX_DIM as MAX_DIM);
// registers 3..5 give, for destination axes 0..2, the source axis as 1=x 2=y 3=z,
// negated to reverse it. Codes that are not a signed permutation raise config_error
// and force dest_index to zero while counting goes on. Any write to a known register
// restarts the walk at the first voxel; unknown indexes are dropped. The block takes
// one voxel per clock when the output is drained. A voxel is written to the queue on
// its transfer, then passes the multiply stage and the output register in turn, and
// the result is held in the output register until it is taken. After reset and
// after each register write the input is held off while the destination strides
// are rebuilt through the setup multiplier.
module volume_axis_permute_address #(
    parameter int MAX_DIM   = 1024,
    parameter int DATA_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    vapa_cfg_if.sink   cfg,
    vapa_in_if.sink    voxel,
    vapa_out_if.source result
);

    localparam int CW      = $clog2(MAX_DIM);
    localparam int ENTRY_W = 3 * CW + DATA_BITS + 1;

    // Setup to front/back: mapping, strides and clamped extents.
    vapa_pkg::setup_t   setup;
    logic [2:0][CW-1:0] ext_m1;
    logic               setup_busy;
    logic               walk_clear;

    // Queue between the counting front and the address back end.
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_wr_data;
    logic [ENTRY_W-1:0] q_rd_data;

    // Decode register writes, clamp extents, build the per-axis strides.
    vapa_setup #(
        .MAX_DIM (MAX_DIM)
    ) u_setup (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .setup  (setup),
        .ext_m1 (ext_m1),
        .busy   (setup_busy),
        .clear  (walk_clear)
    );

    // Advance the source position on each voxel transfer and enqueue it.
    vapa_front #(
        .MAX_DIM   (MAX_DIM),
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .voxel  (voxel),
        .ext_m1 (ext_m1),
        .busy   (setup_busy),
        .clear  (walk_clear),
        .full   (q_full),
        .push   (q_push),
        .entry  (q_wr_data)
    );

    vapa_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .rd_data   (q_rd_data),
        .not_empty (q_valid)
    );

    // Map coordinates to destination offsets, sum, hold in the output register.
    vapa_back #(
        .MAX_DIM   (MAX_DIM),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_rd_data),
        .pop     (q_pop),
        .setup   (setup),
        .ext_m1  (ext_m1),
        .result  (result)
    );

    // The front must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("voxel queue overflow");

    // A bad axis code set must zero the destination index.
    a_err_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.config_error |-> result.dest_index == '0)
        else $error("nonzero index with config error");

    // No voxel transfer while strides are still being rebuilt.
    a_no_accept_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
        voxel.valid && voxel.ready |-> !setup_busy)
        else $error("voxel taken during setup");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DATA_BITS      = 16;
    localparam int TB_MAX_DIM     = 1024;
    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 850;
    localparam int HOLD_CYCLES    = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;

    // Register slots past the end of the map; writes to these must be dropped.
    localparam logic [vapa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [vapa_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_7 = 3'd7;

    // Axis codes: plain, reversed, and the two encodings that name no axis.
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_X    = vapa_pkg::CODE_X;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_Y    = vapa_pkg::CODE_Y;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_Z    = vapa_pkg::CODE_Z;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_NX   = vapa_pkg::CODE_NEG_X;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_NY   = vapa_pkg::CODE_NEG_Y;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_NZ   = vapa_pkg::CODE_NEG_Z;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_ZERO = 3'b000;
    localparam logic [vapa_pkg::CODE_BITS-1:0] AX_BAD  = 3'b100;

    typedef struct {
        vapa_pkg::idx_t       dest_index;
        logic [DATA_BITS-1:0] voxel;
        logic                 last;
        logic                 err;
    } voxel_result_t;

    logic clk = 1'b0;
    logic rst_n;

    vapa_cfg_if                          cfg_bus ();
    vapa_in_if  #(.DATA_BITS(DATA_BITS)) vox_bus ();
    vapa_out_if #(.DATA_BITS(DATA_BITS)) res_bus ();

    volume_axis_permute_address #(
        .MAX_DIM   (TB_MAX_DIM),
        .DATA_BITS (DATA_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .voxel  (vox_bus),
        .result (res_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Shadow copy of the register file and of the source walk position.
    logic [vapa_pkg::SIZE_BITS-1:0] m_size [3];
    logic [vapa_pkg::CODE_BITS-1:0] m_code [3];
    int unsigned                    m_pos  [3];

    // Results still owed by the block, oldest first.
    voxel_result_t pending_results [$];

    int  error_count   = 0;
    bit  vox_offering  = 1'b0;
    bit  cfg_open      = 1'b0;
    bit  gaps_on       = 1'b0;
    int  burst_left    = 0;
    int  rx_stall_max  = 0;
    int  hold_len      = 0;
    int  hold_requests = 0;

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] %s", $time, what);
    endfunction

    // A size of zero reads as one; anything past the maximum extent saturates.
    function automatic int unsigned clamp_extent(input logic [vapa_pkg::SIZE_BITS-1:0] s);
        if (s == '0)
            return 1;
        if (s > TB_MAX_DIM)
            return TB_MAX_DIM;
        return 32'(s);
    endfunction

    // Work out the destination index of the voxel at the current source position,
    // then advance the position in raster order (x fastest, wrap at end of volume).
    function automatic voxel_result_t permute_voxel(input logic [DATA_BITS-1:0] v);
        voxel_result_t                         r;
        int unsigned                           ext    [3];
        int                                    dst_of [3];
        bit                                    flip   [3];
        longint unsigned                       dim    [3];
        longint unsigned                       stride [3];
        longint unsigned                       sum;
        logic signed [vapa_pkg::CODE_BITS-1:0] c;
        int                                    cv;
        int                                    axis;
        int                                    a;
        int                                    j;
        bit                                    ok;
        ok  = 1'b1;
        sum = 0;
        for (a = 0; a < 3; a++) begin
            ext[a]    = clamp_extent(m_size[a]);
            dst_of[a] = -1;
            flip[a]   = 1'b0;
            if (m_pos[a] >= ext[a])
                m_pos[a] = 0;
        end
        // map each source axis to the destination axis whose code names it
        for (j = 0; j < 3; j++) begin
            c    = m_code[j];
            cv   = int'(c);
            axis = (cv < 0) ? -cv : cv;
            if (axis < 1 || axis > 3)
                ok = 1'b0;
            else if (dst_of[axis-1] != -1)
                ok = 1'b0;
            else
            begin
                dst_of[axis-1] = j;
                flip[axis-1]   = (cv < 0);
            end
        end
        if (ok)
        begin
            for (a = 0; a < 3; a++)
                dim[dst_of[a]] = ext[a];
            stride[0] = 1;
            stride[1] = dim[0];
            stride[2] = dim[0] * dim[1];
            for (a = 0; a < 3; a++)
                sum += (flip[a] ? ext[a] - 1 - m_pos[a] : m_pos[a]) * stride[dst_of[a]];
        end
        r.dest_index = ok ? sum[vapa_pkg::IDX_BITS-1:0] : '0;
        r.voxel      = v;
        r.err        = !ok;
        r.last       = (m_pos[0] == ext[0] - 1) && (m_pos[1] == ext[1] - 1)
                       && (m_pos[2] == ext[2] - 1);
        m_pos[0]++;
        if (m_pos[0] >= ext[0])
        begin
            m_pos[0] = 0;
            m_pos[1]++;
            if (m_pos[1] >= ext[1])
            begin
                m_pos[1] = 0;
                m_pos[2]++;
                if (m_pos[2] >= ext[2])
                    m_pos[2] = 0;
            end
        end
        return r;
    endfunction

    // Any write to a known register restarts the walk; unknown slots change nothing.
    function automatic void model_write(input logic [vapa_pkg::CFG_IDX_BITS-1:0] idx,
                                        input logic [vapa_pkg::CFG_DATA_BITS-1:0] data);
        case (idx)
            vapa_pkg::CFG_SIZE_X: m_size[0] = data;
            vapa_pkg::CFG_SIZE_Y: m_size[1] = data;
            vapa_pkg::CFG_SIZE_Z: m_size[2] = data;
            vapa_pkg::CFG_AXIS0:  m_code[0] = data[vapa_pkg::CODE_BITS-1:0];
            vapa_pkg::CFG_AXIS1:  m_code[1] = data[vapa_pkg::CODE_BITS-1:0];
            vapa_pkg::CFG_AXIS2:  m_code[2] = data[vapa_pkg::CODE_BITS-1:0];
            default:              return;
        endcase
        m_pos = '{default: 0};
    endfunction

    // Put random junk above the code bits; the block must ignore it.
    function automatic logic [vapa_pkg::CFG_DATA_BITS-1:0] code_word(
        input logic [vapa_pkg::CODE_BITS-1:0] c);
        logic [vapa_pkg::CFG_DATA_BITS-1:0] w;
        w                          = vapa_pkg::CFG_DATA_BITS'($urandom);
        w[vapa_pkg::CODE_BITS-1:0] = c;
        return w;
    endfunction

    // Mostly small extents so volumes wrap often; now and then zero, oversize or big.
    function automatic logic [vapa_pkg::SIZE_BITS-1:0] pick_extent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 6)
            return '0;
        if (roll < 12)
            return vapa_pkg::SIZE_BITS'($urandom_range(TB_MAX_DIM + 1, 2047));
        if (roll < 18)
            return vapa_pkg::SIZE_BITS'($urandom_range(6, TB_MAX_DIM));
        return vapa_pkg::SIZE_BITS'($urandom_range(1, 5));
    endfunction

    // Drop the voxel valid, but only while a voxel is being offered.
    task automatic stop_input();
        if (vox_offering)
        begin
            vox_bus.valid <= 1'b0;
            vox_offering  = 1'b0;
        end
    endtask

    task automatic close_cfg();
        if (cfg_open)
        begin
            cfg_bus.valid <= 1'b0;
            cfg_open      = 1'b0;
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Offer one voxel, honoring the burst/gap pattern, and hold it until the transfer.
    task automatic send_voxel(input logic [DATA_BITS-1:0] v);
        int gap;
        gap = 0;
        close_cfg();
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = $urandom_range(1, 9);
            end
            burst_left--;
        end
        if (gap > 0)
        begin
            stop_input();
            repeat (gap) @(posedge clk);
        end
        vox_bus.valid    <= 1'b1;
        vox_bus.voxel_in <= v;
        vox_offering     = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!vox_bus.ready);
        pending_results.push_back(permute_voxel(v));
    endtask

    // Write one register with the block idle. Valid stays up so back-to-back writes
    // follow without a gap; the next voxel drops it.
    task automatic write_reg(input logic [vapa_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [vapa_pkg::CFG_DATA_BITS-1:0] data);
        stop_input();
        wait_drained();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        cfg_open      = 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_bus.ready);
        model_write(idx, data);
    endtask

    task automatic program_volume(input logic [vapa_pkg::SIZE_BITS-1:0] sx,
                                  input logic [vapa_pkg::SIZE_BITS-1:0] sy,
                                  input logic [vapa_pkg::SIZE_BITS-1:0] sz,
                                  input logic [vapa_pkg::CODE_BITS-1:0] c0,
                                  input logic [vapa_pkg::CODE_BITS-1:0] c1,
                                  input logic [vapa_pkg::CODE_BITS-1:0] c2);
        write_reg(vapa_pkg::CFG_SIZE_X, sx);
        write_reg(vapa_pkg::CFG_SIZE_Y, sy);
        write_reg(vapa_pkg::CFG_SIZE_Z, sz);
        write_reg(vapa_pkg::CFG_AXIS0, code_word(c0));
        write_reg(vapa_pkg::CFG_AXIS1, code_word(c1));
        write_reg(vapa_pkg::CFG_AXIS2, code_word(c2));
    endtask

    // Reset values: 1x1x1 identity, so every voxel is last and lands at index zero.
    task automatic test_reset_state();
        send_voxel(16'h0000);
        send_voxel(16'hFFFF);
    endtask

    // Oversize extents saturate; all three reversed puts the first voxel at the top
    // index. Zero extents read as one.
    task automatic test_extreme_sizes();
        program_volume(11'h7FF, 11'h7FF, 11'h7FF, AX_NX, AX_NY, AX_NZ);
        send_voxel(16'hFFFF);
        send_voxel(16'h0000);
        program_volume(11'h000, 11'h000, 11'h000, AX_NZ, AX_X, AX_NY);
        send_voxel(16'h5A5A);
        program_volume(11'd1024, 11'd0, 11'd1025, AX_Z, AX_NX, AX_Y);
        send_voxel(16'h8001);
        send_voxel(16'h7FFE);
    endtask

    // Code zero, the minus-four code and a repeated axis must flag an error and
    // zero the index; then a mixed, flipped permutation.
    task automatic test_axis_codes();
        program_volume(11'd2, 11'd2, 11'd1, AX_ZERO, AX_Y, AX_Z);
        send_voxel(DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
        write_reg(vapa_pkg::CFG_AXIS0, code_word(AX_BAD));
        send_voxel(DATA_BITS'($urandom));
        write_reg(vapa_pkg::CFG_AXIS0, code_word(AX_X));
        write_reg(vapa_pkg::CFG_AXIS1, code_word(AX_NX));
        send_voxel(DATA_BITS'($urandom));
        program_volume(11'd3, 11'd2, 11'd2, AX_NY, AX_Z, AX_X);
        send_voxel(DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
    endtask

    // Run past the end of a tiny volume: last flag on the final voxel, then wrap.
    task automatic test_volume_wrap();
        program_volume(11'd2, 11'd1, 11'd2, AX_NZ, AX_X, AX_Y);
        repeat (6) send_voxel(DATA_BITS'($urandom));
    endtask

    // Writes to unmapped slots keep the walk going; a real write restarts it.
    task automatic test_config_restart();
        program_volume(11'd3, 11'd2, 11'd1, AX_Y, AX_NX, AX_Z);
        send_voxel(DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
        write_reg(CFG_SPARE_6, vapa_pkg::CFG_DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
        write_reg(CFG_SPARE_7, vapa_pkg::CFG_DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
        write_reg(vapa_pkg::CFG_SIZE_Y, 11'd2);
        send_voxel(DATA_BITS'($urandom));
        send_voxel(DATA_BITS'($urandom));
    endtask

    // Random volumes: mostly signed permutations with random flips, some raw codes.
    // Each phase rewrites all or part of the register file in shuffled order.
    task automatic test_random_volumes();
        int                             done_items;
        int                             n;
        int                             k;
        int                             t;
        int                             perm  [3];
        logic [vapa_pkg::CODE_BITS-1:0] codes [3];
        vapa_pkg::cfg_idx_t             regs  [6];
        vapa_pkg::cfg_idx_t             tmp;
        longint unsigned                vol;
        bit                             full;
        bit                             wrote;
        bit                             spare;
        done_items = 0;
        while (done_items < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 4) != 0)
            begin
                perm = '{1, 2, 3};
                for (k = 2; k > 0; k--)
                begin
                    t       = $urandom_range(0, k);
                    n       = perm[k];
                    perm[k] = perm[t];
                    perm[t] = n;
                end
                for (k = 0; k < 3; k++)
                    codes[k] = $urandom_range(0, 1) ? vapa_pkg::CODE_BITS'(-perm[k])
                                                    : vapa_pkg::CODE_BITS'(perm[k]);
            end
            else
            begin
                for (k = 0; k < 3; k++)
                    codes[k] = vapa_pkg::CODE_BITS'($urandom);
            end

            regs = '{vapa_pkg::CFG_SIZE_X, vapa_pkg::CFG_SIZE_Y, vapa_pkg::CFG_SIZE_Z,
                     vapa_pkg::CFG_AXIS0, vapa_pkg::CFG_AXIS1, vapa_pkg::CFG_AXIS2};
            for (k = 5; k > 0; k--)
            begin
                t       = $urandom_range(0, k);
                tmp     = regs[k];
                regs[k] = regs[t];
                regs[t] = tmp;
            end
            full  = ($urandom_range(0, 9) < 7);
            wrote = 1'b0;
            for (k = 0; k < 6; k++)
            begin
                if (full || $urandom_range(0, 1) == 1 || (k == 5 && !wrote))
                begin
                    if (regs[k] < vapa_pkg::CFG_AXIS0)
                        write_reg(regs[k], pick_extent());
                    else
                        write_reg(regs[k],
                                  code_word(codes[int'(regs[k]) - int'(vapa_pkg::CFG_AXIS0)]));
                    wrote = 1'b1;
                end
            end

            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 3))
                0:       rx_stall_max = 0;
                1:       rx_stall_max = 2;
                2:       rx_stall_max = 6;
                default: rx_stall_max = 12;
            endcase

            vol = longint'(clamp_extent(m_size[0])) * clamp_extent(m_size[1])
                  * clamp_extent(m_size[2]);
            n     = (vol <= 48) ? $urandom_range(1, 2 * int'(vol) + 1) : $urandom_range(4, 40);
            spare = ($urandom_range(0, 9) == 0);
            for (k = 0; k < n; k++)
            begin
                if (spare && k == n / 2)
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_6 : CFG_SPARE_7,
                              vapa_pkg::CFG_DATA_BITS'($urandom));
                send_voxel(DATA_BITS'($urandom));
            end
            done_items += n;
        end
    endtask

    // Hold the output off for a long stretch while voxels keep coming, so the block
    // fills and stalls its input; then pause until everything drains and resume.
    task automatic test_backpressure();
        program_volume(11'd4, 11'd3, 11'd2, AX_NZ, AX_Y, AX_NX);
        gaps_on      = 1'b0;
        rx_stall_max = 0;
        hold_len     = HOLD_CYCLES;
        hold_requests++;
        repeat (40) send_voxel(DATA_BITS'($urandom));
        stop_input();
        wait_drained();
        gaps_on      = 1'b1;
        rx_stall_max = 3;
        repeat (20) send_voxel(DATA_BITS'($urandom));
    endtask

    // Output side: alternate ready and stall runs of random length; a hold request
    // from the sequence overrides the pattern and keeps ready low until hold_len runs out.
    initial
    begin : receiver
        int run_left;
        int hold_left;
        int holds_taken;
        bit stalling;
        run_left      = 0;
        hold_left     = 0;
        holds_taken   = 0;
        stalling      = 1'b0;
        res_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_taken)
            begin
                holds_taken = hold_requests;
                hold_left   = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                if (run_left == 0)
                begin
                    stalling = !stalling && (rx_stall_max > 0);
                    run_left = stalling ? $urandom_range(1, rx_stall_max)
                                        : $urandom_range(1, 16);
                end
                run_left--;
                res_bus.ready <= !stalling;
            end
        end
    end

    // Check every result transfer against the oldest owed result, field by field.
    always @(posedge clk)
    begin : check_results
        voxel_result_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (pending_results.size() == 0)
                flag_error($sformatf("unexpected result: dest_index %0d voxel %h",
                                     res_bus.dest_index, res_bus.voxel_out));
            else
            begin
                want = pending_results.pop_front();
                if (res_bus.dest_index !== want.dest_index || res_bus.voxel_out !== want.voxel
                    || res_bus.last_voxel !== want.last || res_bus.config_error !== want.err)
                    flag_error($sformatf({"result mismatch (exp/got): dest_index %0d/%0d ",
                                          "voxel %h/%h last %b/%b error %b/%b"},
                                         want.dest_index, res_bus.dest_index,
                                         want.voxel, res_bus.voxel_out,
                                         want.last, res_bus.last_voxel,
                                         want.err, res_bus.config_error));
            end
        end
    end

    // Abort when no transfer of any kind has happened for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((vox_bus.valid && vox_bus.ready) || (res_bus.valid && res_bus.ready)
                || (cfg_bus.valid && cfg_bus.ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] watchdog: %0d cycles without a transfer", $time, quiet);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    initial
    begin
        // mirror the register reset values: unit extents, identity axes
        m_size = '{default: 1};
        m_code = '{AX_X, AX_Y, AX_Z};
        m_pos  = '{default: 0};

        rst_n            = 1'b0;
        vox_bus.valid    = 1'b0;
        vox_bus.voxel_in = '0;
        cfg_bus.valid    = 1'b0;
        cfg_bus.index    = '0;
        cfg_bus.data     = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extreme_sizes();
        test_axis_codes();
        test_volume_wrap();
        test_config_restart();
        test_random_volumes();
        test_backpressure();

        // let the pipeline empty, then give stray results a last chance to show up
        close_cfg();
        stop_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
